// ----- hw/rtl/dart_pkg.sv -----
// shared types, constants and helpers for the divider and reload timer
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps
`default_nettype none

package dart_pkg;

   localparam int CycWidth    = 6;
   localparam int ByteWidth   = 8;
   localparam int PeriodWidth = 11;
   localparam int AddrWidth   = 4;
   localparam int DataWidth   = 32;

   localparam logic [1:0] RegTimerEnable = 2'd0;
   localparam logic [1:0] RegClockSelect = 2'd1;
   localparam logic [1:0] RegReloadValue = 2'd2;

   localparam logic [1:0] SelPeriod1024 = 2'd0;
   localparam logic [1:0] SelPeriod16   = 2'd1;
   localparam logic [1:0] SelPeriod64   = 2'd2;
   localparam logic [1:0] SelPeriod256  = 2'd3;

   localparam logic [PeriodWidth-1:0] PeriodReset = 11'd1024;
   localparam logic [ByteWidth-1:0]   TimerMax    = 8'd255;

   typedef struct packed {
      logic                 timer_enable;
      logic [1:0]           clock_select;
      logic [ByteWidth-1:0] reload_value;
   } cfg_type;

   typedef struct packed {
      logic [ByteWidth-1:0] divider_value;
      logic [ByteWidth-1:0] timer_value;
      logic                 timer_irq;
   } rsp_type;

   function automatic logic [PeriodWidth-1:0] period_of(input logic [1:0] sel);
      logic [PeriodWidth-1:0] p;
      case (sel)
         SelPeriod16:   p = 11'd16;
         SelPeriod64:   p = 11'd64;
         SelPeriod256:  p = 11'd256;
         SelPeriod1024: p = 11'd1024;
         default:       p = 11'd1024;
      endcase
      return p;
   endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/dart_csr.sv -----
// configuration registers behind the apb-style port
// depends on dart_pkg
`timescale 1ns / 1ps
`default_nettype none

module dart_csr
   import dart_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 psel,
   input  wire logic                 penable,
   input  wire logic                 pwrite,
   input  wire logic [AddrWidth-1:0] paddr,
   input  wire logic [DataWidth-1:0] pwdata,
   output logic      [DataWidth-1:0] prdata,
   output logic                      pready,
   output cfg_type                   cfg
);

   cfg_type    cfg_ff;
   logic [1:0] index;
   logic       wr_en;

   assign pready = 1'b1;
   assign index  = paddr[3:2];
   assign wr_en  = psel && penable && pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else if (wr_en) begin
         case (index)
            RegTimerEnable: cfg_ff.timer_enable <= pwdata[0];
            RegClockSelect: cfg_ff.clock_select <= pwdata[1:0];
            RegReloadValue: cfg_ff.reload_value <= pwdata[7:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      case (index)
         RegTimerEnable: prdata = {31'd0, cfg_ff.timer_enable};
         RegClockSelect: prdata = {30'd0, cfg_ff.clock_select};
         RegReloadValue: prdata = {24'd0, cfg_ff.reload_value};
         default:        prdata = '0;
      endcase
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

// ----- hw/rtl/dart_core.sv -----
// divider and timer state with the single-pass next-state logic
// depends on dart_pkg
`timescale 1ns / 1ps
`default_nettype none

module dart_core
   import dart_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                step,
   input  wire logic [CycWidth-1:0] cyc,
   input  cfg_type                  cfg,
   output rsp_type                  rsp
);

   logic [ByteWidth-1:0]   accum_ff, accum_in;
   logic [ByteWidth-1:0]   div_ff, div_in;
   logic [PeriodWidth-1:0] down_ff, down_in;
   logic [1:0]             sel_ff, sel_in;
   logic [ByteWidth-1:0]   timer_ff, timer_in;
   logic [ByteWidth:0]     sum;
   logic [PeriodWidth-1:0] down_cur;
   logic [PeriodWidth-1:0] cyc_ext;
   logic                   irq;

   always_comb begin
      sum      = {1'b0, accum_ff} + {3'd0, cyc};
      accum_in = sum[ByteWidth-1:0];
      div_in   = sum[ByteWidth] ? div_ff + 8'd1 : div_ff;

      cyc_ext  = {{(PeriodWidth-CycWidth){1'b0}}, cyc};
      sel_in   = cfg.clock_select;
      down_cur = (cfg.clock_select != sel_ff) ? period_of(cfg.clock_select) : down_ff;
      down_in  = down_cur;
      timer_in = timer_ff;
      irq      = 1'b0;
      if (cfg.timer_enable) begin
         if (down_cur <= cyc_ext) begin
            down_in = period_of(cfg.clock_select);
            if (timer_ff == TimerMax) begin
               timer_in = cfg.reload_value;
               irq      = 1'b1;
            end else begin
               timer_in = timer_ff + 8'd1;
            end
         end else begin
            down_in = down_cur - cyc_ext;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         accum_ff <= '0;
         div_ff   <= '0;
         down_ff  <= PeriodReset;
         sel_ff   <= '0;
         timer_ff <= '0;
      end else if (step) begin
         accum_ff <= accum_in;
         div_ff   <= div_in;
         down_ff  <= down_in;
         sel_ff   <= sel_in;
         timer_ff <= timer_in;
      end
   end

   assign rsp.divider_value = div_in;
   assign rsp.timer_value   = timer_in;
   assign rsp.timer_irq     = irq;

endmodule

`default_nettype wire

// ----- hw/rtl/divider_and_reload_timer.sv -----
// divider and reload timer: an accepted item passes the input register, then the result register
// throughput one item per cycle unless the result is stalled; input register, one-pass state update, result register
// req_stall rises only while the result register is full and stalled
// synchronous active-high reset: counters cleared, period down-counter at 1024
// configuration registers reset to zero
`timescale 1ns / 1ps
`default_nettype none

module divider_and_reload_timer
   import dart_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_stall,
   input  wire logic [CycWidth-1:0]  req_elapsed_cycles,
   output logic                      rsp_valid,
   input  wire logic                 rsp_stall,
   output logic      [ByteWidth-1:0] rsp_divider_value,
   output logic      [ByteWidth-1:0] rsp_timer_value,
   output logic                      rsp_timer_irq,
   input  wire logic                 psel,
   input  wire logic                 penable,
   input  wire logic                 pwrite,
   input  wire logic [AddrWidth-1:0] paddr,
   input  wire logic [DataWidth-1:0] pwdata,
   output logic      [DataWidth-1:0] prdata,
   output logic                      pready
);

   cfg_type             cfg;
   rsp_type             rsp_next;
   rsp_type             rsp_ff;
   logic                in_valid_ff;
   logic [CycWidth-1:0] in_cyc_ff;
   logic                out_valid_ff;
   logic                advance;

   dart_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   dart_core u_core (
      .clock (clock),
      .reset (reset),
      .step  (advance),
      .cyc   (in_cyc_ff),
      .cfg   (cfg),
      .rsp   (rsp_next)
   );

   assign advance   = in_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (!req_stall) begin
            in_valid_ff <= req_valid;
         end
         if (advance) begin
            out_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         in_cyc_ff <= req_elapsed_cycles;
      end
      if (advance) begin
         rsp_ff <= rsp_next;
      end
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_divider_value = rsp_ff.divider_value;
   assign rsp_timer_value   = rsp_ff.timer_value;
   assign rsp_timer_irq     = rsp_ff.timer_irq;

   a_stall_needs_item: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (in_valid_ff && out_valid_ff && rsp_stall))
      else $error("input stalled without a blocked item");

   a_advance_fills: assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_valid)
      else $error("result register not filled after advance");

   a_irq_reload: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_timer_irq) |-> (rsp_timer_value == cfg.reload_value))
      else $error("interrupt without reload value");

   a_irq_enabled: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !cfg.timer_enable) |-> !rsp_timer_irq)
      else $error("interrupt while timer disabled");

endmodule

`default_nettype wire

// ----- dv/timer_result_checker.sv -----
// result checker for the divider and reload timer: mirrors the register writes,
// predicts one result per accepted item and compares each accepted result in order
// depends on dart_pkg for widths, register and select codes and the result type
`timescale 1ns / 1ps

module timer_result_checker
   import dart_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   input  wire logic                 req_stall,
   input  wire logic [CycWidth-1:0]  req_elapsed_cycles,
   input  wire logic                 rsp_valid,
   input  wire logic                 rsp_stall,
   input  wire logic [ByteWidth-1:0] rsp_divider_value,
   input  wire logic [ByteWidth-1:0] rsp_timer_value,
   input  wire logic                 rsp_timer_irq,
   input  wire logic                 psel,
   input  wire logic                 penable,
   input  wire logic                 pwrite,
   input  wire logic                 pready,
   input  wire logic [AddrWidth-1:0] paddr,
   input  wire logic [DataWidth-1:0] pwdata,
   output int                        fail_count,
   output int                        pending_count,
   output int                        result_count,
   output int                        irq_count
);

   logic                 timer_enable;
   logic [1:0]           clock_select;
   logic [ByteWidth-1:0] reload_value;

   logic [ByteWidth-1:0] divider_accum;
   logic [ByteWidth-1:0] divider_count;
   logic [11:0]          period_down_count;
   logic [1:0]           last_select;
   logic [ByteWidth-1:0] timer_count;

   rsp_type expected_results[$];
   rsp_type predicted;
   rsp_type observed;
   int      errors;
   int      results;
   int      irqs;

   initial begin
      errors = 0;
      results = 0;
      irqs = 0;
      fail_count = 0;
      pending_count = 0;
      result_count = 0;
      irq_count = 0;
   end

   function automatic logic [11:0] period_cycles(input logic [1:0] sel);
      case (sel)
         SelPeriod16:  return 12'd16;
         SelPeriod64:  return 12'd64;
         SelPeriod256: return 12'd256;
         default:      return 12'd1024;
      endcase
   endfunction

   task automatic predict_timer_step(input logic [CycWidth-1:0] cyc, output rsp_type res);
      logic [8:0] sum;
      res.timer_irq = 1'b0;
      sum = {1'b0, divider_accum} + cyc;
      if (sum >= 9'd256) begin
         sum = sum - 9'd256;
         divider_count = divider_count + 1'b1;
      end
      divider_accum = sum[7:0];
      // a new select reloads the down-counter, enabled or not
      if (clock_select != last_select) begin
         period_down_count = period_cycles(clock_select);
         last_select = clock_select;
      end
      if (timer_enable) begin
         if (period_down_count <= {6'd0, cyc}) begin
            period_down_count = period_cycles(clock_select);
            if (timer_count == TimerMax) begin
               timer_count = reload_value;
               res.timer_irq = 1'b1;
            end else begin
               timer_count = timer_count + 1'b1;
            end
         end else begin
            period_down_count = period_down_count - cyc;
         end
      end
      res.divider_value = divider_count;
      res.timer_value = timer_count;
   endtask

   task automatic report_field(input string field, input int wanted, input int seen);
      if (wanted != seen) begin
         $display("%0t ns: %s expected %0d, got %0d", $time, field, wanted, seen);
         errors++;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         timer_enable = 1'b0;
         clock_select = SelPeriod1024;
         reload_value = '0;
         divider_accum = '0;
         divider_count = '0;
         period_down_count = 12'd1024;
         last_select = SelPeriod1024;
         timer_count = '0;
         expected_results.delete();
      end else begin
         if (psel && penable && pwrite && pready) begin
            if (paddr[3:2] == RegTimerEnable)
               timer_enable = pwdata[0];
            else if (paddr[3:2] == RegClockSelect)
               clock_select = pwdata[1:0];
            else if (paddr[3:2] == RegReloadValue)
               reload_value = pwdata[ByteWidth-1:0];
         end
         if (rsp_valid && !rsp_stall) begin
            observed.divider_value = rsp_divider_value;
            observed.timer_value = rsp_timer_value;
            observed.timer_irq = rsp_timer_irq;
            results++;
            if (observed.timer_irq)
               irqs++;
            if (expected_results.size() == 0) begin
               $display("%0t ns: result with nothing expected, got divider %0d timer %0d irq %0d",
                        $time, observed.divider_value, observed.timer_value, observed.timer_irq);
               errors++;
            end else begin
               predicted = expected_results.pop_front();
               report_field("divider_value", predicted.divider_value, observed.divider_value);
               report_field("timer_value", predicted.timer_value, observed.timer_value);
               report_field("timer_irq", predicted.timer_irq, observed.timer_irq);
            end
         end
         if (req_valid && !req_stall) begin
            predict_timer_step(req_elapsed_cycles, predicted);
            expected_results.push_back(predicted);
         end
      end
      fail_count <= errors;
      pending_count <= expected_results.size();
      result_count <= results;
      irq_count <= irqs;
   end

endmodule

// ----- dv/testbench.sv -----
// top of the divider and reload timer testbench: clock, reset, register writes,
// item stimulus with random idling on both channels, watchdog and verdict
// depends on dart_pkg, divider_and_reload_timer and timer_result_checker
`timescale 1ns / 1ps

module testbench;
   import dart_pkg::*;

   localparam int         RandomItems   = 1750;
   localparam int         StuckLimit    = 1000;
   localparam logic [1:0] RegBeyondList = 2'd3;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_stall;
   logic [CycWidth-1:0]  req_elapsed_cycles = '0;
   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   logic [ByteWidth-1:0] rsp_divider_value;
   logic [ByteWidth-1:0] rsp_timer_value;
   logic                 rsp_timer_irq;
   logic                 psel = 1'b0;
   logic                 penable = 1'b0;
   logic                 pwrite = 1'b0;
   logic [AddrWidth-1:0] paddr = '0;
   logic [DataWidth-1:0] pwdata = '0;
   logic [DataWidth-1:0] prdata;
   logic                 pready;

   int fail_count;
   int pending_count;
   int result_count;
   int irq_count;
   int send_idle_pct = 18;
   int recv_idle_pct = 58;
   int items_sent = 0;
   int settings_count = 0;
   int stuck_cycles = 0;

   divider_and_reload_timer u_top (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_elapsed_cycles (req_elapsed_cycles),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_divider_value  (rsp_divider_value),
      .rsp_timer_value    (rsp_timer_value),
      .rsp_timer_irq      (rsp_timer_irq),
      .psel               (psel),
      .penable            (penable),
      .pwrite             (pwrite),
      .paddr              (paddr),
      .pwdata             (pwdata),
      .prdata             (prdata),
      .pready             (pready)
   );

   timer_result_checker u_checker (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_elapsed_cycles (req_elapsed_cycles),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_divider_value  (rsp_divider_value),
      .rsp_timer_value    (rsp_timer_value),
      .rsp_timer_irq      (rsp_timer_irq),
      .psel               (psel),
      .penable            (penable),
      .pwrite             (pwrite),
      .pready             (pready),
      .paddr              (paddr),
      .pwdata             (pwdata),
      .fail_count         (fail_count),
      .pending_count      (pending_count),
      .result_count       (result_count),
      .irq_count          (irq_count)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (reset)
         rsp_stall <= 1'b0;
      else
         rsp_stall <= ($urandom_range(0, 99) < recv_idle_pct);
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (psel && penable)) begin
         stuck_cycles <= 0;
      end else begin
         stuck_cycles <= stuck_cycles + 1;
         if (stuck_cycles >= StuckLimit) begin
            $display("CHECK FAILED");
            $finish;
         end
      end
   end

   task automatic send_item(input logic [CycWidth-1:0] cyc);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_elapsed_cycles <= cyc;
      do @(posedge clock); while (req_stall);
      items_sent++;
      if (items_sent == 600) begin
         send_idle_pct = 58;
         recv_idle_pct = 18;
      end else if (items_sent == 1200) begin
         send_idle_pct = 0;
         recv_idle_pct = 0;
      end
   endtask

   // stop sending and let every outstanding result come back
   task automatic wait_idle();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_count != 0);
   endtask

   task automatic write_register(input logic [1:0] index, input logic [DataWidth-1:0] value);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= {index, 2'b00};
      pwdata <= value;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      @(posedge clock);
   endtask

   task automatic write_settings(input logic en, input logic [1:0] sel,
                                 input logic [ByteWidth-1:0] reload);
      write_register(RegTimerEnable, {31'($urandom_range(0, 32'h7fff_ffff)), en});
      write_register(RegClockSelect, {30'($urandom_range(0, 32'h3fff_ffff)), sel});
      write_register(RegReloadValue, {24'($urandom_range(0, 32'h00ff_ffff)), reload});
      settings_count++;
   endtask

   function automatic logic [CycWidth-1:0] random_cycles();
      int pick;
      pick = $urandom_range(0, 9);
      if (pick == 0)
         return '0;
      else if (pick == 1)
         return '1;
      else if (pick == 2)
         return CycWidth'($urandom_range(1, 4));
      else
         return CycWidth'($urandom_range(0, 63));
   endfunction

   initial begin
      int                   round;
      int                   count;
      int                   pick;
      logic                 en;
      logic [1:0]           sel;
      logic [ByteWidth-1:0] reload;

      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset settings: timer disabled, divider only, zero cycles included
      send_item(6'd0);
      send_item(6'd63);
      send_item(6'd1);
      wait_idle();

      // select change while disabled and a write beyond the register list
      write_register(RegReloadValue, 32'd255);
      write_register(RegClockSelect, {30'd0, SelPeriod256});
      write_register(RegBeyondList, 32'hffff_ffff);
      settings_count++;
      send_item(6'd5);
      wait_idle();

      // enabled at 16: expiry with discarded excess, exact hit, zero cycles
      write_register(RegTimerEnable, 32'd1);
      write_register(RegClockSelect, {30'd0, SelPeriod16});
      settings_count++;
      send_item(6'd63);
      send_item(6'd16);
      send_item(6'd15);
      send_item(6'd1);
      send_item(6'd0);
      send_item(6'd0);
      wait_idle();

      // select change while enabled
      write_register(RegClockSelect, {30'd0, SelPeriod64});
      settings_count++;
      send_item(6'd63);
      send_item(6'd1);
      send_item(6'd63);
      wait_idle();

      write_register(RegClockSelect, {30'd0, SelPeriod1024});
      settings_count++;
      repeat (4) send_item(6'd63);
      wait_idle();

      write_settings(1'b0, SelPeriod1024, 8'd0);
      send_item(6'd63);
      send_item(6'd0);
      wait_idle();

      round = 0;
      count = items_sent + RandomItems;
      while (items_sent < count) begin
         en = ($urandom_range(0, 9) < 8);
         if (round < 4)
            sel = round[1:0];
         else if ($urandom_range(0, 9) < 4)
            sel = SelPeriod16;
         else
            sel = 2'($urandom_range(0, 3));
         pick = $urandom_range(0, 3);
         if (pick == 0)
            reload = 8'd0;
         else if (pick == 1)
            reload = 8'd255;
         else
            reload = 8'($urandom_range(0, 255));
         write_settings(en, sel, reload);
         repeat ($urandom_range(60, 180)) send_item(random_cycles());
         wait_idle();
         round++;
      end

      wait_idle();
      repeat (6) @(posedge clock);
      $display("run covered %0d items and %0d results over %0d register settings",
               items_sent, result_count, settings_count);
      $display("timer interrupts seen: %0d", irq_count);
      if (fail_count == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule

// ----- sim.f -----
hw/rtl/dart_pkg.sv
hw/rtl/dart_csr.sv
hw/rtl/dart_core.sv
hw/rtl/divider_and_reload_timer.sv
dv/timer_result_checker.sv
dv/testbench.sv
